FILE: design/ca160_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ca160_pkg;

  localparam int unsigned AccW     = 40;
  localparam int unsigned GrpW     = 5;
  localparam int unsigned CharW    = 7;
  localparam int unsigned LastByte = 20;

  localparam logic [AccW-1:0] SeedMain = 40'd1058337025301;
  localparam logic [AccW-1:0] SeedTest = 40'd584719417569;

  localparam logic [AccW-1:0] Gen0 = 40'h98f2bc8e61;
  localparam logic [AccW-1:0] Gen1 = 40'h79b76d99e2;
  localparam logic [AccW-1:0] Gen2 = 40'hf33e5fb3c4;
  localparam logic [AccW-1:0] Gen3 = 40'hae2eabe2a8;
  localparam logic [AccW-1:0] Gen4 = 40'h1e4f43e470;

  localparam logic [3:0] PrefixLenMain = 4'd12;
  localparam logic [3:0] PrefixLenTest = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREFIX,
    ST_DATA,
    ST_PAD,
    ST_CALC,
    ST_CSUM
  } emit_state_t;

  // word offered by the emitter plus its status toward the top level
  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] char_code;
    logic             last_char;
    logic             final_word;
    logic             busy;
  } emit_t;

  // base32 alphabet, ASCII codes
  function automatic logic [CharW-1:0] b32_char(input logic [GrpW-1:0] g);
    logic [CharW-1:0] c;
    case (g)
      5'd0:  c = 7'h71;
      5'd1:  c = 7'h70;
      5'd2:  c = 7'h7a;
      5'd3:  c = 7'h72;
      5'd4:  c = 7'h79;
      5'd5:  c = 7'h39;
      5'd6:  c = 7'h78;
      5'd7:  c = 7'h38;
      5'd8:  c = 7'h67;
      5'd9:  c = 7'h66;
      5'd10: c = 7'h32;
      5'd11: c = 7'h74;
      5'd12: c = 7'h76;
      5'd13: c = 7'h64;
      5'd14: c = 7'h77;
      5'd15: c = 7'h30;
      5'd16: c = 7'h73;
      5'd17: c = 7'h33;
      5'd18: c = 7'h6a;
      5'd19: c = 7'h6e;
      5'd20: c = 7'h35;
      5'd21: c = 7'h34;
      5'd22: c = 7'h6b;
      5'd23: c = 7'h68;
      5'd24: c = 7'h63;
      5'd25: c = 7'h65;
      5'd26: c = 7'h36;
      5'd27: c = 7'h6d;
      5'd28: c = 7'h75;
      5'd29: c = 7'h61;
      5'd30: c = 7'h37;
      5'd31: c = 7'h6c;
      default: c = 7'h71;
    endcase
    return c;
  endfunction

  // prefix text, ASCII codes; the colon closes both variants
  function automatic logic [CharW-1:0] prefix_char(input logic test, input logic [3:0] idx);
    logic [CharW-1:0] c;
    case ({test, idx})
      5'h00: c = 7'h62;
      5'h01: c = 7'h69;
      5'h02: c = 7'h74;
      5'h03: c = 7'h63;
      5'h04: c = 7'h6f;
      5'h05: c = 7'h69;
      5'h06: c = 7'h6e;
      5'h07: c = 7'h63;
      5'h08: c = 7'h61;
      5'h09: c = 7'h73;
      5'h0a: c = 7'h68;
      5'h0b: c = 7'h3a;
      5'h10: c = 7'h62;
      5'h11: c = 7'h63;
      5'h12: c = 7'h68;
      5'h13: c = 7'h74;
      5'h14: c = 7'h65;
      5'h15: c = 7'h73;
      5'h16: c = 7'h74;
      5'h17: c = 7'h3a;
      default: c = 7'h3a;
    endcase
    return c;
  endfunction

  // low-bit mask for a leftover count of 0..4
  function automatic logic [3:0] lo_mask(input logic [2:0] cnt);
    logic [4:0] m;
    m = (5'd1 << cnt) - 5'd1;
    return m[3:0];
  endfunction

endpackage
`default_nettype wire

FILE: design/ca160_polystep.sv
`timescale 1ns / 1ps
`default_nettype none
module ca160_polystep (
  input  wire logic [ca160_pkg::AccW-1:0] acc_i,
  input  wire logic [ca160_pkg::GrpW-1:0] grp_i,
  output logic      [ca160_pkg::AccW-1:0] acc_o
);

  logic [4:0] top;

  assign top = acc_i[39:35];

  always_comb begin
    acc_o = {acc_i[34:0], grp_i};
    if (top[0]) acc_o = acc_o ^ ca160_pkg::Gen0;
    if (top[1]) acc_o = acc_o ^ ca160_pkg::Gen1;
    if (top[2]) acc_o = acc_o ^ ca160_pkg::Gen2;
    if (top[3]) acc_o = acc_o ^ ca160_pkg::Gen3;
    if (top[4]) acc_o = acc_o ^ ca160_pkg::Gen4;
  end

endmodule
`default_nettype wire

FILE: design/ca160_emit.sv
`timescale 1ns / 1ps
`default_nettype none
module ca160_emit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire logic [7:0]           byte_value,
  input  wire logic                 is_testnet,
  input  wire logic                 with_prefix,
  input  wire logic                 take,
  output ca160_pkg::emit_t          emit
);

  ca160_pkg::emit_state_t state_r, state_nxt;
  logic [4:0]                 byte_idx_r, byte_idx_nxt;
  logic [11:0]                buf_r, buf_nxt;
  logic [3:0]                 cnt_r, cnt_nxt;
  logic [ca160_pkg::AccW-1:0] acc_r, acc_nxt;
  logic [3:0]                 sub_r, sub_nxt;
  logic                       sel_test_r, sel_test_nxt;
  logic                       last_byte_r, last_byte_nxt;

  logic [3:0]                 sh;
  logic                       more;
  logic [ca160_pkg::GrpW-1:0] data_grp, pad_grp, csum_grp, grp_in;
  logic [8:0]                 pad_wide;
  logic [5:0]                 csh;
  logic [3:0]                 lc_src;
  logic [3:0]                 prefix_len;
  logic                       fire, first;
  logic [2:0]                 lc_l;
  logic [3:0]                 lb_l;
  logic [ca160_pkg::AccW-1:0] step_acc, z1_acc, z2_acc;

  // groups of the held byte, the padded tail group and the checksum groups
  assign sh       = cnt_r - 4'd5;
  assign more     = (sh >= 4'd5);
  assign data_grp = 5'(buf_r >> sh[2:0]);
  assign pad_wide = {5'd0, buf_r[3:0] & ca160_pkg::lo_mask(cnt_r[2:0])} << (3'd5 - cnt_r[2:0]);
  assign pad_grp  = pad_wide[4:0];
  assign csh      = 6'(3'd7 - sub_r[2:0]) * 6'd5;
  assign csum_grp = 5'(acc_r >> csh);
  assign grp_in   = (state_r == ca160_pkg::ST_PAD) ? pad_grp : data_grp;
  assign prefix_len = sel_test_r ? ca160_pkg::PrefixLenTest : ca160_pkg::PrefixLenMain;

  ca160_polystep u_step (.acc_i(acc_r),  .grp_i(grp_in), .acc_o(step_acc));
  ca160_polystep u_z0   (.acc_i(acc_r),  .grp_i(5'd0),   .acc_o(z1_acc));
  ca160_polystep u_z1   (.acc_i(z1_acc), .grp_i(5'd0),   .acc_o(z2_acc));

  always_comb begin
    emit = '0;
    emit.busy = (state_r != ca160_pkg::ST_IDLE);
    case (state_r)
      ca160_pkg::ST_PREFIX: begin
        emit.valid     = 1'b1;
        emit.char_code = ca160_pkg::prefix_char(sel_test_r, sub_r);
      end
      ca160_pkg::ST_DATA: begin
        emit.valid      = 1'b1;
        emit.char_code  = ca160_pkg::b32_char(data_grp);
        emit.final_word = !more && !last_byte_r;
      end
      ca160_pkg::ST_PAD: begin
        emit.valid     = 1'b1;
        emit.char_code = ca160_pkg::b32_char(pad_grp);
      end
      ca160_pkg::ST_CSUM: begin
        emit.valid      = 1'b1;
        emit.char_code  = ca160_pkg::b32_char(csum_grp);
        emit.last_char  = (sub_r == 4'd7);
        emit.final_word = (sub_r == 4'd7);
      end
      default: begin
      end
    endcase
  end

  assign fire   = emit.valid && take;
  assign first  = (byte_idx_r == 5'd0);
  assign lc_src = (state_r == ca160_pkg::ST_DATA) ? sh : cnt_r;
  assign lc_l   = first ? 3'd0 : lc_src[2:0];
  assign lb_l   = first ? 4'd0 : (buf_r[3:0] & ca160_pkg::lo_mask(lc_src[2:0]));

  always_comb begin
    state_nxt     = state_r;
    byte_idx_nxt  = byte_idx_r;
    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    sub_nxt       = sub_r;
    sel_test_nxt  = sel_test_r;
    last_byte_nxt = last_byte_r;

    case (state_r)
      ca160_pkg::ST_PREFIX: begin
        if (fire) begin
          sub_nxt = sub_r + 4'd1;
          if (sub_r == prefix_len - 4'd1) state_nxt = ca160_pkg::ST_DATA;
        end
      end
      ca160_pkg::ST_DATA: begin
        if (fire) begin
          acc_nxt = step_acc;
          cnt_nxt = sh;
          if (!more) state_nxt = last_byte_r ? ca160_pkg::ST_PAD : ca160_pkg::ST_IDLE;
        end
      end
      ca160_pkg::ST_PAD: begin
        if (fire) begin
          acc_nxt   = step_acc;
          sub_nxt   = 4'd0;
          state_nxt = ca160_pkg::ST_CALC;
        end
      end
      ca160_pkg::ST_CALC: begin
        // two zero steps a cycle
        acc_nxt = z2_acc;
        sub_nxt = sub_r + 4'd1;
        if (sub_r == 4'd3) begin
          acc_nxt   = z2_acc ^ 40'd1;
          sub_nxt   = 4'd0;
          state_nxt = ca160_pkg::ST_CSUM;
        end
      end
      ca160_pkg::ST_CSUM: begin
        if (fire) begin
          sub_nxt = sub_r + 4'd1;
          if (sub_r == 4'd7) state_nxt = ca160_pkg::ST_IDLE;
        end
      end
      default: begin
      end
    endcase

    // a new byte lands on the cycle its predecessor sends its final word
    if (load) begin
      buf_nxt       = {lb_l, byte_value};
      cnt_nxt       = {1'b0, lc_l} + 4'd8;
      last_byte_nxt = (byte_idx_r == 5'(ca160_pkg::LastByte));
      byte_idx_nxt  = last_byte_nxt ? 5'd0 : byte_idx_r + 5'd1;
      state_nxt     = ca160_pkg::ST_DATA;
      if (first) begin
        acc_nxt      = is_testnet ? ca160_pkg::SeedTest : ca160_pkg::SeedMain;
        sel_test_nxt = is_testnet;
        if (with_prefix) begin
          state_nxt = ca160_pkg::ST_PREFIX;
          sub_nxt   = 4'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ca160_pkg::ST_IDLE;
      byte_idx_r <= 5'd0;
      cnt_r      <= 4'd0;
      sub_r      <= 4'd0;
    end else begin
      state_r    <= state_nxt;
      byte_idx_r <= byte_idx_nxt;
      cnt_r      <= cnt_nxt;
      sub_r      <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r       <= buf_nxt;
    acc_r       <= acc_nxt;
    sel_test_r  <= sel_test_nxt;
    last_byte_r <= last_byte_nxt;
  end

endmodule
`default_nettype wire

FILE: design/cashaddr_encoder_160_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming address-string encoder for a type byte plus a 20-byte hash.
// Feed the 21 bytes of one address in order on the in_ channel; the out_
// channel returns ASCII characters one word per cycle, except while the
// output stalls or the checksum is being finished: the optional prefix
// and colon (12 characters for mainnet, 8 for testnet), 34 base32 data
// characters (last one zero padded) and 8 checksum characters, with
// out_last_char high on the final checksum character. A middle byte
// yields 1 or 2 characters, the first byte adds the prefix characters,
// and the last byte yields two data characters, then the checksum
// finishing (two polymod steps per cycle) and the checksum characters;
// the character emitter sets the rate. A registered output stage lets
// the next byte be taken on the same cycle its predecessor's final word
// is handed over.
// is_testnet and with_prefix are sampled when the first byte of an address
// is taken; write them only while the block is idle.
module cashaddr_encoder_160_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte_value,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [6:0]      out_char_code,
  output logic            out_last_char,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic       cfg_wdata
);

  localparam logic CfgIsTestnet  = 1'b0;
  localparam logic CfgWithPrefix = 1'b1;

  logic              is_testnet_r, with_prefix_r;
  logic              out_valid_r;
  logic [6:0]        out_char_r;
  logic              out_last_r;
  logic              out_take;
  logic              in_fire;
  ca160_pkg::emit_t  emit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_testnet_r  <= 1'b0;
      with_prefix_r <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == CfgIsTestnet)  is_testnet_r  <= cfg_wdata;
      if (cfg_index == CfgWithPrefix) with_prefix_r <= cfg_wdata;
    end
  end

  // output register accepts a new word when empty or draining this cycle
  assign out_take = !out_valid_r || out_ready;

  // take a byte when idle, or when the held byte's final word moves out
  assign in_ready = !emit.busy || (emit.final_word && out_take);
  assign in_fire  = in_valid && in_ready;

  ca160_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (in_fire),
    .byte_value  (in_byte_value),
    .is_testnet  (is_testnet_r),
    .with_prefix (with_prefix_r),
    .take        (out_take),
    .emit        (emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= emit.valid;
    end
  end

  // payload: hold while stalled, advance with each new word
  always_ff @(posedge clk) begin
    if (out_take && emit.valid) begin
      out_char_r <= emit.char_code;
      out_last_r <= emit.last_char;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

  // a byte is taken mid-item only as the held byte's final word leaves
  a_accept_on_final : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && emit.busy) |-> (emit.final_word && emit.valid && out_take))
    else $error("byte accepted while emitter still had words to send");

  // the closing checksum character always ends the held item
  a_last_is_final : assert property (@(posedge clk) disable iff (!rst_n)
    (emit.valid && emit.last_char) |-> emit.final_word)
    else $error("last character not marked as final word");

  // a word handed to the output stage shows up there next cycle
  a_word_lands : assert property (@(posedge clk) disable iff (!rst_n)
    (emit.valid && out_take) |=> out_valid_r)
    else $error("emitted word lost before output register");

endmodule
`default_nettype wire
